// ----- design/bfa_pkg.sv -----
package bfa_pkg;

	localparam int LEVELS  = 10;
	localparam int NODE_W  = LEVELS + 1;
	localparam int NODES   = 1 << NODE_W;
	localparam int LV_W    = $clog2(LEVELS + 2);
	localparam int ADDR_W  = 48;
	localparam int REQ_W   = 41;
	localparam int ORD_W   = 6;
	localparam int MINO_W  = 5;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	localparam logic [MINO_W-1:0] GRAIN_RST = MINO_W'(12);

	// register select is paddr[3]
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_MINO = 1'b1;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_ORDER,
		ST_A_SEARCH,
		ST_A_POP_RD,
		ST_A_POP_WR,
		ST_A_SPLIT,
		ST_PUSH1,
		ST_PUSH2,
		ST_A_MARK,
		ST_F_CHECK,
		ST_F_TZ,
		ST_F_DESC_RD,
		ST_F_DESC_CHK,
		ST_F_ORD,
		ST_F_MRG_RD,
		ST_F_MRG_CHK,
		ST_F_UNLINK,
		ST_FINISH
	} state_t;

endpackage

// ----- design/buddy_frame_allocator.sv -----
// Buddy allocator over 2^(grain + 10) bytes starting at base_address.
// Input channel (in_valid/in_stall): mode 0 allocates request_bytes, mode 1
// frees free_address. One transfer in, exactly one result transfer out
// (block_address, alloc_failed, block_order) on out_valid/out_stall.
// A sequencer drives one used-bit RAM and two link RAMs (next/prev) plus
// eleven free-list head registers. An allocation runs an order search, a
// free-list search and then one split per level; a free runs an alignment
// scan, a descend through used child nodes and then one merge per level.
// in_stall is high while an item is being worked on, so the block takes no
// new item before it is through with the last one.
// After reset the used-bit and link RAMs are cleared, one entry per cycle,
// over all 2048 entries; in_stall stays high then. Register writes over the
// APB port are taken at any time but are meant for idle periods.
// The result sits in an output register; while out_stall holds it, the
// block still accepts and works on the next item and waits at its end.
module buddy_frame_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0]         paddr,
	input  logic [bfa_pkg::PDATA_W-1:0]         pwdata,
	output logic [bfa_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [bfa_pkg::REQ_W-1:0]           request_bytes,
	input  logic [bfa_pkg::ADDR_W-1:0]          free_address,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bfa_pkg::ADDR_W-1:0]          block_address,
	output logic                                alloc_failed,
	output logic [bfa_pkg::ORD_W-1:0]           block_order
);

	localparam int NW = bfa_pkg::NODE_W;
	localparam int LW = bfa_pkg::LV_W;
	localparam int OW = bfa_pkg::ORD_W;
	localparam int AW = bfa_pkg::ADDR_W;
	localparam int SW = bfa_pkg::REQ_W + 1;

	bfa_pkg::state_t state_q, state_d;

	logic [AW-1:0]                 base_q;
	logic [bfa_pkg::MINO_W-1:0]    grain_q;
	logic [NW-1:0]                 heads_q [bfa_pkg::LEVELS+1];
	logic [NW-1:0]                 clr_q;
	logic                          mode_q;
	logic [bfa_pkg::REQ_W-1:0]     sz_q;
	logic [AW-1:0]                 offset_q;
	logic [OW-1:0]                 order_q;
	logic [LW-1:0]                 lv_q, k_q;
	logic [NW-1:0]                 n_q, h_q;
	logic [AW-1:0]                 res_addr_q;
	logic                          res_fail_q;
	logic [OW-1:0]                 res_order_q;
	logic                          out_valid_q;
	logic [AW-1:0]                 out_addr_q;
	logic                          out_fail_q;
	logic [OW-1:0]                 out_order_q;

	logic                          used_we, used_wdata, used_rdata;
	logic [NW-1:0]                 used_waddr, used_raddr;
	logic                          nxt_we, prv_we;
	logic [NW-1:0]                 nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;
	logic [NW-1:0]                 prv_waddr, prv_wdata, prv_raddr, prv_rdata;

	logic                          cfg_wr, accept, deliver, out_free;
	logic [OW-1:0]                 top_ord;
	logic [LW-1:0]                 lv_of_order, push_lv;
	logic [NW-1:0]                 push_n, buddy, head_k, free_node;
	logic                          order_fits, range_bad, align_bad;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign prdata   = (paddr[3] == bfa_pkg::REG_MINO) ? bfa_pkg::PDATA_W'(grain_q)
	                                                : bfa_pkg::PDATA_W'(base_q);

	assign in_stall = (state_q != bfa_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_valid     = out_valid_q;
	assign block_address = out_addr_q;
	assign alloc_failed  = out_fail_q;
	assign block_order   = out_order_q;
	assign out_free = !out_valid_q || !out_stall;
	assign deliver  = (state_q == bfa_pkg::ST_FINISH) && out_free;

	assign top_ord     = OW'(grain_q) + OW'(bfa_pkg::LEVELS);
	assign lv_of_order = LW'(order_q - OW'(grain_q));
	assign order_fits  = ((SW'(1) << order_q) >= {1'b0, sz_q});
	assign range_bad   = ((offset_q >> top_ord) != '0);
	assign align_bad   = ((offset_q & ((AW'(1) << grain_q) - AW'(1))) != '0);
	assign head_k      = (k_q <= LW'(bfa_pkg::LEVELS)) ? heads_q[k_q] : '0;
	assign buddy       = n_q ^ NW'(1);
	assign push_n      = (mode_q == bfa_pkg::MODE_FREE) ? n_q : {n_q[NW-2:0], 1'b1};
	assign push_lv     = (mode_q == bfa_pkg::MODE_FREE) ? lv_q : (k_q - LW'(1));
	assign free_node   = NW'(offset_q >> order_q)
	                   + (NW'(1) << (LW'(bfa_pkg::LEVELS) - lv_of_order));

	bfa_ram #(.WIDTH(1), .DEPTH(bfa_pkg::NODES)) u_used (
		.clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
		.raddr(used_raddr), .rdata(used_rdata)
	);
	bfa_ram #(.WIDTH(NW), .DEPTH(bfa_pkg::NODES)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(nxt_raddr), .rdata(nxt_rdata)
	);
	bfa_ram #(.WIDTH(NW), .DEPTH(bfa_pkg::NODES)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(prv_raddr), .rdata(prv_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfa_pkg::ST_CLEAR: if (clr_q == '1) state_d = bfa_pkg::ST_IDLE;
			bfa_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (mode == bfa_pkg::MODE_FREE) ? bfa_pkg::ST_F_CHECK
					                                      : bfa_pkg::ST_A_ORDER;
				end
			end
			bfa_pkg::ST_A_ORDER: begin
				if (order_q > top_ord) state_d = bfa_pkg::ST_FINISH;
				else if (order_fits) state_d = bfa_pkg::ST_A_SEARCH;
			end
			bfa_pkg::ST_A_SEARCH: begin
				if (k_q > LW'(bfa_pkg::LEVELS)) state_d = bfa_pkg::ST_FINISH;
				else if (head_k != '0) state_d = bfa_pkg::ST_A_POP_RD;
			end
			bfa_pkg::ST_A_POP_RD: state_d = bfa_pkg::ST_A_POP_WR;
			bfa_pkg::ST_A_POP_WR: state_d = bfa_pkg::ST_A_SPLIT;
			bfa_pkg::ST_A_SPLIT: begin
				state_d = (k_q > lv_q) ? bfa_pkg::ST_PUSH1 : bfa_pkg::ST_A_MARK;
			end
			bfa_pkg::ST_PUSH1: state_d = bfa_pkg::ST_PUSH2;
			bfa_pkg::ST_PUSH2: begin
				state_d = (mode_q == bfa_pkg::MODE_FREE) ? bfa_pkg::ST_FINISH
				                                        : bfa_pkg::ST_A_SPLIT;
			end
			bfa_pkg::ST_A_MARK: state_d = bfa_pkg::ST_FINISH;
			bfa_pkg::ST_F_CHECK: begin
				state_d = (range_bad || align_bad) ? bfa_pkg::ST_FINISH : bfa_pkg::ST_F_TZ;
			end
			bfa_pkg::ST_F_TZ: begin
				if (!(order_q < top_ord && !offset_q[order_q])) begin
					state_d = bfa_pkg::ST_F_DESC_RD;
				end
			end
			bfa_pkg::ST_F_DESC_RD: begin
				state_d = (lv_q == '0) ? bfa_pkg::ST_F_ORD : bfa_pkg::ST_F_DESC_CHK;
			end
			bfa_pkg::ST_F_DESC_CHK: begin
				state_d = used_rdata ? bfa_pkg::ST_F_DESC_RD : bfa_pkg::ST_F_ORD;
			end
			bfa_pkg::ST_F_ORD: state_d = bfa_pkg::ST_F_MRG_RD;
			bfa_pkg::ST_F_MRG_RD: begin
				state_d = (lv_q == LW'(bfa_pkg::LEVELS)) ? bfa_pkg::ST_PUSH1
				                                         : bfa_pkg::ST_F_MRG_CHK;
			end
			bfa_pkg::ST_F_MRG_CHK: begin
				state_d = used_rdata ? bfa_pkg::ST_PUSH1 : bfa_pkg::ST_F_UNLINK;
			end
			bfa_pkg::ST_F_UNLINK: state_d = bfa_pkg::ST_F_MRG_RD;
			bfa_pkg::ST_FINISH: if (out_free) state_d = bfa_pkg::ST_IDLE;
			default: state_d = bfa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		used_we    = 1'b0;
		used_waddr = n_q;
		used_wdata = 1'b0;
		used_raddr = buddy;
		nxt_we     = 1'b0;
		nxt_waddr  = push_n;
		nxt_wdata  = h_q;
		nxt_raddr  = buddy;
		prv_we     = 1'b0;
		prv_waddr  = push_n;
		prv_wdata  = '0;
		prv_raddr  = buddy;
		unique case (state_q)
			bfa_pkg::ST_CLEAR: begin
				used_we    = 1'b1;
				used_waddr = clr_q;
				nxt_we     = 1'b1;
				nxt_waddr  = clr_q;
				nxt_wdata  = '0;
				prv_we     = 1'b1;
				prv_waddr  = clr_q;
			end
			bfa_pkg::ST_A_POP_RD: nxt_raddr = n_q;
			bfa_pkg::ST_A_POP_WR: begin
				prv_we    = (nxt_rdata != '0);
				prv_waddr = nxt_rdata;
			end
			bfa_pkg::ST_PUSH1: begin
				used_we    = (mode_q == bfa_pkg::MODE_ALLOC) && (k_q < LW'(bfa_pkg::LEVELS));
				used_wdata = 1'b1;
				nxt_we     = 1'b1;
				nxt_wdata  = heads_q[push_lv];
				prv_we     = 1'b1;
			end
			bfa_pkg::ST_PUSH2: begin
				prv_we    = (h_q != '0);
				prv_waddr = h_q;
				prv_wdata = push_n;
			end
			bfa_pkg::ST_A_MARK: begin
				used_we    = (lv_q < LW'(bfa_pkg::LEVELS));
				used_wdata = 1'b1;
			end
			bfa_pkg::ST_F_DESC_RD: used_raddr = {n_q[NW-2:0], 1'b0};
			bfa_pkg::ST_F_MRG_RD: used_we = (lv_q != LW'(bfa_pkg::LEVELS));
			bfa_pkg::ST_F_UNLINK: begin
				prv_we    = (nxt_rdata != '0);
				prv_waddr = nxt_rdata;
				prv_wdata = prv_rdata;
				nxt_we    = (prv_rdata != '0);
				nxt_waddr = prv_rdata;
				nxt_wdata = nxt_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfa_pkg::ST_CLEAR;
			clr_q       <= '0;
			base_q      <= '0;
			grain_q     <= bfa_pkg::GRAIN_RST;
			out_valid_q <= 1'b0;
			for (int i = 0; i <= bfa_pkg::LEVELS; i++) begin
				heads_q[i] <= (i == bfa_pkg::LEVELS) ? NW'(1) : '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == bfa_pkg::ST_CLEAR) clr_q <= clr_q + NW'(1);
			if (cfg_wr) begin
				if (paddr[3] == bfa_pkg::REG_BASE) base_q <= pwdata[AW-1:0];
				else grain_q <= pwdata[bfa_pkg::MINO_W-1:0];
			end
			if (deliver) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				bfa_pkg::ST_A_POP_WR: heads_q[k_q] <= nxt_rdata;
				bfa_pkg::ST_PUSH1: heads_q[push_lv] <= push_n;
				bfa_pkg::ST_F_UNLINK: if (prv_rdata == '0) heads_q[lv_q] <= nxt_rdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			out_addr_q  <= res_addr_q;
			out_fail_q  <= res_fail_q;
			out_order_q <= res_order_q;
		end
		case (state_q)
			bfa_pkg::ST_IDLE: begin
				mode_q      <= mode;
				sz_q        <= request_bytes;
				offset_q    <= free_address - base_q;
				order_q     <= OW'(grain_q);
				res_addr_q  <= '0;
				res_fail_q  <= (mode == bfa_pkg::MODE_ALLOC);
				res_order_q <= '0;
			end
			bfa_pkg::ST_A_ORDER: begin
				if (order_fits) begin
					lv_q <= lv_of_order;
					k_q  <= lv_of_order;
				end else begin
					order_q <= order_q + OW'(1);
				end
			end
			bfa_pkg::ST_A_SEARCH: begin
				if (head_k != '0) n_q <= head_k;
				else k_q <= k_q + LW'(1);
			end
			bfa_pkg::ST_PUSH1: h_q <= heads_q[push_lv];
			bfa_pkg::ST_PUSH2: begin
				if (mode_q == bfa_pkg::MODE_ALLOC) begin
					n_q <= {n_q[NW-2:0], 1'b0};
					k_q <= k_q - LW'(1);
				end
			end
			bfa_pkg::ST_A_MARK: begin
				res_fail_q  <= 1'b0;
				res_order_q <= order_q;
				res_addr_q  <= base_q + (AW'(n_q - (NW'(1) << (LW'(bfa_pkg::LEVELS) - lv_q)))
				               << order_q);
			end
			bfa_pkg::ST_F_TZ: begin
				if (order_q < top_ord && !offset_q[order_q]) begin
					order_q <= order_q + OW'(1);
				end else begin
					lv_q <= lv_of_order;
					n_q  <= free_node;
				end
			end
			bfa_pkg::ST_F_DESC_CHK: begin
				if (used_rdata) begin
					n_q  <= {n_q[NW-2:0], 1'b0};
					lv_q <= lv_q - LW'(1);
				end
			end
			bfa_pkg::ST_F_ORD: res_order_q <= OW'(grain_q) + OW'(lv_q);
			bfa_pkg::ST_F_UNLINK: begin
				n_q  <= n_q >> 1;
				lv_q <= lv_q + LW'(1);
			end
			default: ;
		endcase
	end

endmodule

// ----- design/bfa_ram.sv -----
module bfa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && waddr == raddr) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/bfa_chk.sv -----
module bfa_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [bfa_pkg::ADDR_W-1:0]  block_address,
	input logic                        alloc_failed,
	input logic [bfa_pkg::ORD_W-1:0]   block_order
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alloc_failed |-> block_address == '0 && block_order == '0)
		else $error("failed allocation carries data");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer taken while busy");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result too early");

endmodule

bind buddy_frame_allocator bfa_chk u_bfa_chk (.*);

// ----- dv/buddy_frame_allocator_tb.sv -----
`timescale 1ns / 1ps

module buddy_frame_allocator_tb;

	localparam int ADDR_W  = bfa_pkg::ADDR_W;
	localparam int ORD_W   = bfa_pkg::ORD_W;
	localparam int REQ_W   = bfa_pkg::REQ_W;
	localparam int PADDR_W = bfa_pkg::PADDR_W;
	localparam int PDATA_W = bfa_pkg::PDATA_W;
	localparam int NODE_W  = bfa_pkg::NODE_W;
	localparam int NODES   = bfa_pkg::NODES;
	localparam int LEVELS  = bfa_pkg::LEVELS;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              failed;
		logic [ORD_W-1:0]  order;
	} alloc_result_t;

	localparam int STALL_LIMIT = 20000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                mode = bfa_pkg::MODE_ALLOC;
	logic [REQ_W-1:0]    request_bytes = '0;
	logic [ADDR_W-1:0]   free_address = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [ADDR_W-1:0]   block_address;
	logic                alloc_failed;
	logic [ORD_W-1:0]    block_order;

	buddy_frame_allocator uut (.*);

	always #2 clk = ~clk;

	// shadow allocator state
	logic [ADDR_W-1:0]  cfg_base = '0;
	int unsigned        cfg_grain = 12;
	bit                 used_map [NODES];
	logic [NODE_W-1:0]  head_of [LEVELS+1];
	logic [NODE_W-1:0]  next_of [NODES];
	logic [NODE_W-1:0]  prev_of [NODES];
	bit                 next_known [NODES];
	bit                 prev_known [NODES];
	bit                 undef_read;

	bit                 sv_used [NODES];
	logic [NODE_W-1:0]  sv_head [LEVELS+1];
	logic [NODE_W-1:0]  sv_next [NODES];
	logic [NODE_W-1:0]  sv_prev [NODES];
	bit                 sv_nk [NODES];
	bit                 sv_pk [NODES];

	alloc_result_t      pending_results [$];
	logic [ADDR_W-1:0]  held_blocks [$];
	int                 mismatches = 0;
	int                 sent_items = 0;
	int                 checked_results = 0;
	int                 skipped_items = 0;
	int                 alloc_fails = 0;
	bit                 idle_on = 1'b1;
	bit                 hold_req = 1'b0;

	function automatic void fl_push(int unsigned lv, logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] h;
		h = head_of[lv];
		prev_of[n] = '0; prev_known[n] = 1'b1;
		next_of[n] = h;  next_known[n] = 1'b1;
		if (h != 0) begin
			prev_of[h] = n; prev_known[h] = 1'b1;
		end
		head_of[lv] = n;
	endfunction

	function automatic logic [NODE_W-1:0] fl_pop(int unsigned lv);
		logic [NODE_W-1:0] n, nx;
		n = head_of[lv];
		if (!next_known[n]) undef_read = 1'b1;
		nx = next_of[n];
		if (nx != 0) begin
			prev_of[nx] = '0; prev_known[nx] = 1'b1;
		end
		head_of[lv] = nx;
		return n;
	endfunction

	function automatic void fl_unlink(int unsigned lv, logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] pv, nx;
		if (!prev_known[n] || !next_known[n]) undef_read = 1'b1;
		pv = prev_of[n];
		nx = next_of[n];
		if (nx != 0) begin
			prev_of[nx] = pv; prev_known[nx] = 1'b1;
		end
		if (pv != 0) begin
			next_of[pv] = nx; next_known[pv] = 1'b1;
		end else
			head_of[lv] = nx;
	endfunction

	function automatic alloc_result_t predict_alloc(logic [REQ_W-1:0] rq);
		alloc_result_t r;
		int unsigned order, lv, k;
		logic [NODE_W-1:0] n;
		logic [63:0] rel;
		r = '{addr: '0, failed: 1'b1, order: '0};
		order = 0;
		while (order < 63 && (64'd1 << order) < 64'(rq)) order++;
		if (order < cfg_grain) order = cfg_grain;
		if (order > cfg_grain + LEVELS) return r;
		lv = order - cfg_grain;
		k = lv;
		while (k <= LEVELS && head_of[k] == 0) k++;
		if (k > LEVELS) return r;
		n = fl_pop(k);
		while (k > lv) begin
			if (k < LEVELS) used_map[n] = 1'b1;
			fl_push(k - 1, NODE_W'(2 * n + 1));
			n = NODE_W'(2 * n);
			k--;
		end
		if (lv < LEVELS) used_map[n] = 1'b1;
		rel = 64'(n) - (64'd1 << (LEVELS - lv));
		r.addr = ADDR_W'(64'(cfg_base) + (rel << order));
		r.failed = 1'b0;
		r.order = ORD_W'(order);
		return r;
	endfunction

	function automatic alloc_result_t predict_free(logic [ADDR_W-1:0] fa);
		alloc_result_t r;
		int unsigned top_ord, order, lv;
		logic [63:0] offset;
		logic [NODE_W-1:0] n, child, buddy;
		r = '0;
		top_ord = cfg_grain + LEVELS;
		offset = 64'(ADDR_W'(fa - cfg_base));
		if ((offset >> top_ord) != 0) return r;
		order = 0;
		if (offset == 0)
			order = top_ord;
		else
			while (offset[order] == 1'b0) order++;
		if (order < cfg_grain) return r;
		lv = order - cfg_grain;
		n = NODE_W'((offset >> order) + (64'd1 << (LEVELS - lv)));
		while (lv > 0) begin
			child = NODE_W'(2 * n);
			if (!used_map[child]) break;
			n = child;
			lv--;
		end
		r.order = ORD_W'(cfg_grain + lv);
		while (lv < LEVELS) begin
			buddy = n ^ NODE_W'(1);
			used_map[n] = 1'b0;
			if (used_map[buddy]) break;
			fl_unlink(lv, buddy);
			n = n >> 1;
			lv++;
		end
		fl_push(lv, n);
		return r;
	endfunction

	task automatic shadow_reset();
		for (int i = 0; i < NODES; i++) begin
			used_map[i] = 1'b0;
			next_of[i] = '0; prev_of[i] = '0;
			next_known[i] = 1'b0; prev_known[i] = 1'b0;
		end
		for (int i = 0; i <= LEVELS; i++) head_of[i] = '0;
		head_of[LEVELS] = NODE_W'(1);
		// top node links are defined by reset
		next_known[1] = 1'b1; prev_known[1] = 1'b1;
	endtask

	task automatic apb_write(logic reg_sel, logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {reg_sel, 3'b000}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic configure(logic [ADDR_W-1:0] base, int unsigned grain);
		drain();
		apb_write(bfa_pkg::REG_BASE, PDATA_W'(base));
		apb_write(bfa_pkg::REG_MINO, PDATA_W'(grain));
		cfg_base = base;
		cfg_grain = grain;
		held_blocks.delete();
	endtask

	// predict on a snapshot; items that would touch unwritten links are dropped
	task automatic send_item(logic md, logic [REQ_W-1:0] rq, logic [ADDR_W-1:0] fa);
		alloc_result_t r;
		sv_used = used_map; sv_head = head_of; sv_next = next_of; sv_prev = prev_of;
		sv_nk = next_known; sv_pk = prev_known;
		undef_read = 1'b0;
		r = (md == bfa_pkg::MODE_ALLOC) ? predict_alloc(rq) : predict_free(fa);
		if (undef_read) begin
			used_map = sv_used; head_of = sv_head; next_of = sv_next; prev_of = sv_prev;
			next_known = sv_nk; prev_known = sv_pk;
			skipped_items++;
			return;
		end
		if (md == bfa_pkg::MODE_ALLOC && !r.failed) held_blocks.push_back(r.addr);
		if (md == bfa_pkg::MODE_ALLOC && r.failed) alloc_fails++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md; request_bytes <= rq; free_address <= fa;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(r);
		sent_items++;
	endtask

	task automatic idle_input();
		in_valid <= 1'b0;
	endtask

	task automatic random_item();
		int unsigned sh, pick, idx;
		logic [63:0] rnd;
		logic [ADDR_W-1:0] a;
		rnd = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (held_blocks.size() != 0 && pick < 45) begin
			idx = $urandom_range(0, held_blocks.size() - 1);
			a = held_blocks[idx];
			held_blocks.delete(idx);
			send_item(bfa_pkg::MODE_FREE, REQ_W'(rnd), a);
		end else if (pick < 52) begin
			send_item(bfa_pkg::MODE_FREE, REQ_W'(rnd), ADDR_W'({$urandom, $urandom}));
		end else if (pick < 58) begin
			sh = $urandom_range(0, cfg_grain + LEVELS - 1);
			a = cfg_base + ADDR_W'((rnd & ((64'd1 << (cfg_grain + LEVELS)) - 1))
				& ~((64'd1 << sh) - 1) | (64'd1 << sh));
			send_item(bfa_pkg::MODE_FREE, REQ_W'(rnd), a);
		end else if (pick < 64) begin
			send_item(bfa_pkg::MODE_ALLOC, REQ_W'({$urandom, $urandom}), ADDR_W'(rnd));
		end else begin
			sh = $urandom_range(0, cfg_grain + LEVELS / 2);
			send_item(bfa_pkg::MODE_ALLOC, REQ_W'(rnd & ((64'd1 << sh) - 1)),
				ADDR_W'(rnd >> 7));
		end
	endtask

	task automatic test_directed();
		logic [REQ_W-1:0] top;
		top = REQ_W'(64'd1 << (cfg_grain + LEVELS));
		send_item(bfa_pkg::MODE_ALLOC, '0, '0);
		send_item(bfa_pkg::MODE_ALLOC, REQ_W'(1), '1);
		send_item(bfa_pkg::MODE_ALLOC, REQ_W'(4096), '0);
		send_item(bfa_pkg::MODE_ALLOC, REQ_W'(4097), '0);
		send_item(bfa_pkg::MODE_ALLOC, top, '0);
		send_item(bfa_pkg::MODE_ALLOC, top + 1'b1, '0);
		send_item(bfa_pkg::MODE_ALLOC, REQ_W'(64'd1 << 40), '0);
		send_item(bfa_pkg::MODE_ALLOC, '1, '0);
		send_item(bfa_pkg::MODE_FREE, '1, ADDR_W'(4096 * 5 + 1));
		send_item(bfa_pkg::MODE_FREE, '0, ADDR_W'(top));
		send_item(bfa_pkg::MODE_FREE, '0, '1);
		send_item(bfa_pkg::MODE_FREE, '0, ADDR_W'(4096));
		send_item(bfa_pkg::MODE_FREE, '0, ADDR_W'(8192));
		send_item(bfa_pkg::MODE_FREE, '0, '0);
		send_item(bfa_pkg::MODE_FREE, '0, '0);
		send_item(bfa_pkg::MODE_ALLOC, REQ_W'(top >> 1), '0);
		send_item(bfa_pkg::MODE_ALLOC, REQ_W'(top >> 1), '0);
		send_item(bfa_pkg::MODE_ALLOC, REQ_W'(4096), '0);
		send_item(bfa_pkg::MODE_FREE, '0, ADDR_W'(top >> 1));
		send_item(bfa_pkg::MODE_FREE, '0, '0);
		held_blocks.delete();
	endtask

	task automatic test_random(int count);
		repeat (count) random_item();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (30) random_item();
		idle_input();
		drain();
	endtask

	task automatic test_config_extremes();
		configure(ADDR_W'(0), 5);
		test_random(70);
		configure(ADDR_W'(48'hFF00_0000_0000), 30);
		test_random(70);
		configure(ADDR_W'(48'hFFFF_FFFF_8000), 5);
		test_random(50);
		configure(ADDR_W'(48'h1234_0000_0000), 20);
		test_random(70);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: addr=%h failed=%b order=%0d",
						block_address, alloc_failed, block_order);
			end else begin
				e = pending_results.pop_front();
				checked_results++;
				if (e.addr !== block_address || e.failed !== alloc_failed ||
					e.order !== block_order) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp addr=%h failed=%b order=%0d, got addr=%h failed=%b order=%0d",
							e.addr, e.failed, e.order, block_address, alloc_failed, block_order);
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		shadow_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		configure(ADDR_W'(0), 12);
		test_directed();
		test_random(120);
		test_backpressure();
		test_config_extremes();
		configure(ADDR_W'(0), 12);
		idle_on = 1'b0;
		test_random(90);
		idle_input();
		drain();
		$display("sent %0d transfers, checked %0d results (%0d failed allocations), %0d dropped",
			sent_items, checked_results, alloc_fails, skipped_items);
		$display("block grains 2^5/12/20/30, base at zero, high and top of space, %0d mismatches",
			mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/bfa_pkg.sv
design/bfa_ram.sv
design/buddy_frame_allocator.sv
design/bfa_chk.sv
dv/buddy_frame_allocator_tb.sv
